### rtl/url_percent_encoder_assert.svh
// assertion macros for the url percent encoder
// used by upe_out_seq; no other dependencies
`ifndef URL_PERCENT_ENCODER_ASSERT_SVH
`define URL_PERCENT_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
`define UPE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UPE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UPE_ASSERT(lbl, clk, rst_n, prop, msg)
`define UPE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/upe_pkg.sv
// shared types, character codes and helpers for the url percent encoder
// no dependencies
package upe_pkg;

    typedef enum logic [2:0] {
        RG_PREFIX   = 3'd0,
        RG_COLON    = 3'd1,
        RG_COLSLASH = 3'd2,
        RG_HOST     = 3'd3,
        RG_PATH     = 3'd4,
        RG_QPEND    = 3'd5,
        RG_QUERY    = 3'd6
    } t_region;

    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_EQUALS   = 8'h3D;
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [3:0] NIB_MASK    = 4'hF;

    localparam int MAX_RES = 4;

    typedef logic [7:0] t_byte;
    typedef logic [MAX_RES-1:0][7:0] t_byte_vec;

    // results of one request, handed from the encoder to the output sequencer
    typedef struct packed {
        t_byte_vec  bytes;
        logic [2:0] cnt;      // number of results, 0 to 4
        logic       has_byte; // 0 only for the empty closing marker
        logic       last;     // final byte of the url
    } t_enc_res;

    localparam t_byte HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    function automatic logic is_unreserved(input t_byte c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]})
            || (c == CH_DASH) || (c == CH_UNDER) || (c == CH_DOT) || (c == CH_TILDE);
    endfunction

endpackage

### rtl/upe_encode.sv
// combinational encoder: next region state and up to four result bytes
// depends on upe_pkg
module upe_encode
    import upe_pkg::*;
(
    input  t_region  i_region,
    input  logic     i_eq_seen,
    input  t_byte    i_c,
    input  logic     i_last,
    output t_region  o_region_nxt,
    output logic     o_eq_nxt,
    output t_enc_res o_res
);

    logic       eq_eff;
    logic       q_pass;
    logic       unres;
    t_byte      hex_hi;
    t_byte      hex_lo;
    t_byte_vec  bytes;
    logic [2:0] cnt;

    assign eq_eff = (i_region == RG_QPEND) ? 1'b0 : i_eq_seen;
    assign q_pass = (i_c == CH_AMP) || ((i_c == CH_EQUALS) && !eq_eff);
    assign unres  = is_unreserved(i_c);
    assign hex_hi = HEX_DIGITS[i_c[7:4] & NIB_MASK];
    assign hex_lo = HEX_DIGITS[i_c[3:0] & NIB_MASK];

    // next state
    always_comb begin
        o_region_nxt = RG_PREFIX;
        o_eq_nxt     = i_eq_seen;
        case (i_region)
            RG_COLON: begin
                if (i_c == CH_SLASH) begin
                    o_region_nxt = RG_COLSLASH;
                end else if (i_c == CH_COLON) begin
                    o_region_nxt = RG_COLON;
                end
            end
            RG_COLSLASH: begin
                if (i_c == CH_SLASH) begin
                    o_region_nxt = RG_HOST;
                end else if (i_c == CH_QUESTION) begin
                    o_region_nxt = RG_QPEND;
                end else begin
                    o_region_nxt = RG_PATH;
                end
            end
            RG_HOST: begin
                o_region_nxt = (i_c == CH_SLASH) ? RG_PATH : RG_HOST;
            end
            RG_PATH: begin
                o_region_nxt = (i_c == CH_QUESTION) ? RG_QPEND : RG_PATH;
            end
            RG_QPEND, RG_QUERY: begin
                o_region_nxt = RG_QUERY;
                if (i_c == CH_AMP) begin
                    o_eq_nxt = 1'b0;
                end else if ((i_c == CH_EQUALS) && !eq_eff) begin
                    o_eq_nxt = 1'b1;
                end else begin
                    o_eq_nxt = eq_eff;
                end
            end
            default: begin
                if (i_c == CH_COLON) begin
                    o_region_nxt = RG_COLON;
                end else if (i_c == CH_SLASH) begin
                    o_region_nxt = RG_PATH;
                end
            end
        endcase
        // a finished url leaves the state as after reset
        if (i_last) begin
            o_region_nxt = RG_PREFIX;
            o_eq_nxt     = 1'b0;
        end
    end

    // result bytes
    always_comb begin
        bytes = '0;
        cnt   = 3'd1;
        bytes[0] = i_c;
        case (i_region)
            RG_COLSLASH, RG_PATH: begin
                if ((i_region == RG_PATH || i_c != CH_SLASH) && i_c != CH_SLASH) begin
                    if (i_c == CH_QUESTION) begin
                        cnt = 3'd0;
                    end else if (!unres) begin
                        bytes[0] = CH_PERCENT;
                        bytes[1] = hex_hi;
                        bytes[2] = hex_lo;
                        cnt      = 3'd3;
                    end
                end
            end
            RG_QPEND: begin
                bytes[0] = CH_QUESTION;
                bytes[1] = i_c;
                cnt      = 3'd2;
                if (!q_pass && !unres) begin
                    bytes[1] = CH_PERCENT;
                    bytes[2] = hex_hi;
                    bytes[3] = hex_lo;
                    cnt      = 3'd4;
                end
            end
            RG_QUERY: begin
                if (!q_pass && !unres) begin
                    bytes[0] = CH_PERCENT;
                    bytes[1] = hex_hi;
                    bytes[2] = hex_lo;
                    cnt      = 3'd3;
                end
            end
            default: begin
                cnt = 3'd1;
            end
        endcase

        o_res.has_byte = 1'b1;
        o_res.last     = i_last;
        o_res.bytes    = bytes;
        o_res.cnt      = cnt;
        // empty closing marker
        if (i_last && cnt == 3'd0) begin
            o_res.bytes    = '0;
            o_res.cnt      = 3'd1;
            o_res.has_byte = 1'b0;
        end
    end

endmodule

### rtl/upe_out_seq.sv
// result register: holds one request's result bytes and sends one per cycle while i_out_ready is high
// depends on upe_pkg and url_percent_encoder_assert.svh
`include "url_percent_encoder_assert.svh"
module upe_out_seq
    import upe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_enc_res i_res,
    output logic     o_free,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_byte    o_out_byte,
    output logic     o_has_byte,
    output logic     o_run_end,
    output logic     o_url_end
);

    logic       r_valid, n_valid;
    logic [1:0] r_idx, n_idx;
    logic [2:0] r_cnt;
    t_byte_vec  r_bytes;
    logic       r_has;
    logic       r_last;
    logic       at_end;

    assign at_end = ({1'b0, r_idx} == (r_cnt - 3'd1));
    assign o_free = !r_valid || (i_out_ready && at_end);

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (r_valid && i_out_ready) begin
            n_idx = r_idx + 2'd1;
            if (at_end) begin
                n_valid = 1'b0;
            end
        end
        if (i_load) begin
            n_valid = (i_res.cnt != 3'd0);
            n_idx   = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_res.bytes;
            r_cnt   <= i_res.cnt;
            r_has   <= i_res.has_byte;
            r_last  <= i_res.last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_bytes[r_idx];
    assign o_has_byte  = r_has;
    assign o_run_end   = at_end;
    assign o_url_end   = at_end && r_last;

    `UPE_ASSERT(a_idx_in_range, i_clk, i_rst_n, r_valid |-> ({1'b0, r_idx} < r_cnt), "index past count")
    `UPE_ASSERT(a_marker_closes, i_clk, i_rst_n, (r_valid && !r_has) |-> (o_run_end && o_url_end), "marker not last")
    `UPE_ASSERT(a_run_no_gap, i_clk, i_rst_n, (r_valid && i_out_ready && !at_end) |=> r_valid, "gap inside run")
    `UPE_ASSERT(a_load_when_free, i_clk, i_rst_n, i_load |-> o_free, "load while busy")

endmodule

### rtl/url_percent_encoder.sv
// url percent encoder: a request passes through the input register and then the result register
// before its first result; one result byte per cycle while i_out_ready is high; a request
// expands to zero to four bytes on the one-byte output channel
// synchronous active-low reset returns the region to the prefix state
// and empties both the input register and the result register
module url_percent_encoder
    import upe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_byte i_in_byte,
    input  logic  i_end_of_input,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_byte o_out_byte,
    output logic  o_has_byte,
    output logic  o_run_end,
    output logic  o_url_end
);

    // input register
    logic    r_in_valid;
    t_byte   r_in_byte;
    logic    r_in_last;

    // url parsing state
    t_region  r_region;
    t_region  n_region;
    logic     r_eq_seen;
    logic     n_eq_seen;

    t_enc_res enc_res;
    logic     buf_free;
    logic     load;

    // request moves into the result register whenever that register is empty or drains
    assign load       = r_in_valid && buf_free;
    assign o_in_ready = !r_in_valid || buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_end_of_input;
        end
    end

    // state advances once per request, when its results are loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region  <= RG_PREFIX;
            r_eq_seen <= 1'b0;
        end else if (load) begin
            r_region  <= n_region;
            r_eq_seen <= n_eq_seen;
        end
    end

    upe_encode u_encode (
        .i_region     (r_region),
        .i_eq_seen    (r_eq_seen),
        .i_c          (r_in_byte),
        .i_last       (r_in_last),
        .o_region_nxt (n_region),
        .o_eq_nxt     (n_eq_seen),
        .o_res        (enc_res)
    );

    upe_out_seq u_out_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_res       (enc_res),
        .o_free      (buf_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_has_byte  (o_has_byte),
        .o_run_end   (o_run_end),
        .o_url_end   (o_url_end)
    );

endmodule
